@@ rtl/sstf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_pkg
// Types, sizes and codes shared by the shortest-seek-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int SECTOR_W    = 48;
    localparam int TAG_W       = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    // The scan registers the keys first and then moves through each cell in turn.
    localparam int SCAN_CYCLES = QUEUE_DEPTH + 2;
    localparam int CNT_W       = $clog2(SCAN_CYCLES);

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_REMOVE   = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    // Contents of one queue cell.
    typedef struct packed {
        logic                valid;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
    } t_slot;

    // Best candidate so far, handed from cell to cell.
    typedef struct packed {
        logic                found;
        logic [SECTOR_W-1:0] key;
        logic [IDX_W-1:0]    idx;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
    } t_scan;

    // What every cell is looking for during a scan.
    typedef struct packed {
        logic                dispatch;
        logic [TAG_W-1:0]    tag;
        logic [SECTOR_W-1:0] head;
    } t_bcast;

    // Update command broadcast to all cells.
    typedef struct packed {
        logic                add;
        logic                del;
        logic [IDX_W-1:0]    idx;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
    } t_cmd;

endpackage
`default_nettype wire

@@ rtl/sstf_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_req_if
// Request channel: operation, sector and tag with valid/ready.
// ----------------------------------------------------------------------------
interface sstf_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic [sstf_pkg::SECTOR_W-1:0] sector;
    logic [sstf_pkg::TAG_W-1:0]    tag;

    modport source (output valid, op, sector, tag, input ready);
    modport sink   (input valid, op, sector, tag, output ready);
endinterface
`default_nettype wire

@@ rtl/sstf_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_rsp_if
// Response channel: dispatch result and status with valid/ready.
// ----------------------------------------------------------------------------
interface sstf_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          dispatched;
    logic [sstf_pkg::SECTOR_W-1:0] out_sector;
    logic [sstf_pkg::TAG_W-1:0]    out_tag;
    logic [1:0]                    status;

    modport source (output valid, dispatched, out_sector, out_tag, status, input ready);
    modport sink   (input valid, dispatched, out_sector, out_tag, status, output ready);
endinterface
`default_nettype wire

@@ rtl/sstf_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_cell
// One queue entry: holds a request, computes its key and passes the best
// candidate on to the next cell.
// ----------------------------------------------------------------------------
module sstf_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire [sstf_pkg::IDX_W-1:0]    i_index,
    input  sstf_pkg::t_bcast             i_bcast,
    input  sstf_pkg::t_cmd               i_cmd,
    input  wire                          i_left_valid,
    input  sstf_pkg::t_slot              i_right,
    input  sstf_pkg::t_scan              i_scan,
    output sstf_pkg::t_slot              o_slot,
    output sstf_pkg::t_scan              o_scan
);
    import sstf_pkg::*;

    logic                r_valid;
    logic [SECTOR_W-1:0] r_sector;
    logic [TAG_W-1:0]    r_tag;
    logic                r_cand;
    logic [SECTOR_W-1:0] r_key;
    t_scan               r_scan;

    logic                n_cand;
    logic [SECTOR_W-1:0] n_key;
    t_scan               n_scan;
    logic                take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.del && (i_index >= i_cmd.idx)) begin
            r_valid <= i_right.valid;
        end else if (i_cmd.add && !r_valid && i_left_valid) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.del && (i_index >= i_cmd.idx)) begin
            r_sector <= i_right.sector;
            r_tag    <= i_right.tag;
        end else if (i_cmd.add && !r_valid && i_left_valid) begin
            r_sector <= i_cmd.sector;
            r_tag    <= i_cmd.tag;
        end
    end

    // Dispatch ranks by true seek distance; remove ranks all tag matches
    // equally, so the earliest one wins.
    always_comb begin
        if (i_bcast.dispatch) begin
            n_cand = r_valid;
            n_key  = (r_sector >= i_bcast.head) ? (r_sector - i_bcast.head)
                                                : (i_bcast.head - r_sector);
        end else begin
            n_cand = r_valid && (r_tag == i_bcast.tag);
            n_key  = '0;
        end
    end

    always_comb begin
        take = r_cand && (!i_scan.found || (r_key < i_scan.key));
        if (take) begin
            n_scan.found  = 1'b1;
            n_scan.key    = r_key;
            n_scan.idx    = i_index;
            n_scan.sector = r_sector;
            n_scan.tag    = r_tag;
        end else begin
            n_scan = i_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_key  <= n_key;
        r_scan <= n_scan;
    end

    assign o_slot.valid  = r_valid;
    assign o_slot.sector = r_sector;
    assign o_slot.tag    = r_tag;
    assign o_scan        = r_scan;

endmodule
`default_nettype wire

@@ rtl/sstf_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sstf_ctrl
// Sequencer: takes a request, waits for the cell scan, updates the cells,
// the head position and the response register.
// ----------------------------------------------------------------------------
module sstf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    sstf_req_if.sink         i_req,
    sstf_rsp_if.source       o_rsp,
    input  wire              i_first_valid,
    input  wire              i_last_valid,
    input  sstf_pkg::t_scan  i_scan,
    output sstf_pkg::t_bcast o_bcast,
    output sstf_pkg::t_cmd   o_cmd
);
    import sstf_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_op                 r_op;
    logic [SECTOR_W-1:0] r_sector;
    logic [TAG_W-1:0]    r_tag;
    logic [SECTOR_W-1:0] r_head;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic                r_out_disp;
    logic [SECTOR_W-1:0] r_out_sector;
    logic [TAG_W-1:0]    r_out_tag;
    t_status             r_out_status;

    logic                accept;
    logic                scan_done;
    logic                slot_free;
    logic                finish;
    logic                res_disp;
    logic [SECTOR_W-1:0] res_sector;
    logic [TAG_W-1:0]    res_tag;
    t_status             res_status;

    assign accept    = i_req.valid && i_req.ready;
    assign scan_done = (r_cnt == CNT_W'(SCAN_CYCLES - 1));
    assign slot_free = !r_out_valid || o_rsp.ready;
    assign finish    = (r_state == S_EXEC) && slot_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_op'(i_req.op) inside {OP_DISPATCH, OP_REMOVE}) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_op'(i_req.op);
            r_sector <= i_req.sector;
            r_tag    <= i_req.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == S_SCAN) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else begin
            r_cnt <= '0;
        end
    end

    // Result of the current transaction, valid in S_EXEC.
    always_comb begin
        res_disp   = 1'b0;
        res_sector = '0;
        res_tag    = '0;
        res_status = ST_OK;
        o_cmd      = '0;
        case (r_op)
            OP_ADD: begin
                if (i_last_valid) begin
                    res_status = ST_FULL;
                end else begin
                    o_cmd.add    = finish;
                    o_cmd.sector = r_sector;
                    o_cmd.tag    = r_tag;
                end
            end
            OP_DISPATCH: begin
                if (!i_first_valid) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_disp   = 1'b1;
                    res_sector = i_scan.sector;
                    res_tag    = i_scan.tag;
                    o_cmd.del  = finish;
                    o_cmd.idx  = i_scan.idx;
                end
            end
            OP_REMOVE: begin
                if (!i_scan.found) begin
                    res_status = ST_NOT_FOUND;
                end else begin
                    o_cmd.del = finish;
                    o_cmd.idx = i_scan.idx;
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (finish && res_disp) begin
            r_head <= res_sector;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_disp   <= res_disp;
            r_out_sector <= res_sector;
            r_out_tag    <= res_tag;
            r_out_status <= res_status;
        end
    end

    assign o_bcast.dispatch = (r_op == OP_DISPATCH);
    assign o_bcast.tag      = r_tag;
    assign o_bcast.head     = r_head;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.dispatched = r_out_disp;
    assign o_rsp.out_sector = r_out_sector;
    assign o_rsp.out_tag    = r_out_tag;
    assign o_rsp.status     = r_out_status;

endmodule
`default_nettype wire

@@ rtl/sstf_request_scheduler.sv @@
`default_nettype none
// Add and unused op codes go from acceptance straight to S_EXEC; dispatch and
// remove pass through S_SCAN first, which lasts as long as the candidate scan
// that moves one cell per cycle along the chain of queue cells.
// One transaction at a time: S_EXEC waits for a free response register, and
// the next is accepted once the response is registered. Synchronous active-low
// reset empties the queue, zeroes the head position and clears the response.
// ----------------------------------------------------------------------------
// sstf_request_scheduler
// Shortest-seek-first disk request queue built as a chain of cells.
// ----------------------------------------------------------------------------
module sstf_request_scheduler (
    input  wire        i_clk,
    input  wire        i_rst_n,
    sstf_req_if.sink   i_req,
    sstf_rsp_if.source o_rsp
);
    import sstf_pkg::*;

    t_slot  slot [QUEUE_DEPTH];
    t_scan  scan [QUEUE_DEPTH];
    t_bcast bcast;
    t_cmd   cmd;

    sstf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_rsp        (o_rsp),
        .i_first_valid(slot[0].valid),
        .i_last_valid (slot[QUEUE_DEPTH-1].valid),
        .i_scan       (scan[QUEUE_DEPTH-1]),
        .o_bcast      (bcast),
        .o_cmd        (cmd)
    );

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_slot right;
        t_scan left_scan;
        logic  left_valid;

        if (g == 0) begin : g_first
            assign left_scan  = '0;
            assign left_valid = 1'b1;
        end else begin : g_mid
            assign left_scan  = scan[g-1];
            assign left_valid = slot[g-1].valid;
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign right = '0;
        end else begin : g_inner
            assign right = slot[g+1];
        end

        sstf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_index     (IDX_W'(g)),
            .i_bcast     (bcast),
            .i_cmd       (cmd),
            .i_left_valid(left_valid),
            .i_right     (right),
            .i_scan      (left_scan),
            .o_slot      (slot[g]),
            .o_scan      (scan[g])
        );
    end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shortest-seek-first request scheduler. A
// directed opening covers the empty, tie, duplicate-tag and unused-op cases.
// Random add, dispatch and remove traffic follows, with random gaps on
// both channels. Every response is checked against a behavioral queue model
// that is updated as each request transaction is accepted.
// ----------------------------------------------------------------------------
module tb_top;
    import sstf_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 12;
    localparam int          RANDOM_CMDS    = 1000;
    localparam int          LONG_HOLD_AT   = 300;
    localparam int          LONG_HOLD_LEN  = 400;
    localparam int          TAIL_CYCLES    = 2 * (QUEUE_DEPTH + 4) + 50;
    localparam int unsigned TIMEOUT_CYCLES = 1_000_000;
    localparam logic [SECTOR_W-1:0] SECTOR_MAX = '1;
    localparam logic [TAG_W-1:0]    TAG_MAX    = '1;

    typedef struct {
        t_op                 op;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
        int unsigned         gap;
        bit                  drain_first;
    } t_disk_cmd;

    typedef struct {
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
    } t_disk_req;

    typedef struct packed {
        logic                dispatched;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
        t_status             status;
    } t_sched_rsp;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                drv_valid  = 1'b0;
    logic [1:0]          drv_op     = OP_NONE;
    logic [SECTOR_W-1:0] drv_sector = '0;
    logic [TAG_W-1:0]    drv_tag    = '0;
    logic                rsp_ready  = 1'b0;

    int unsigned fail_count  = 0;
    int unsigned rsp_count   = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left   = 0;
    int unsigned stall_mode  = 0;

    t_disk_cmd           cmd_queue[$];
    t_disk_req           pending_reqs[$];
    t_sched_rsp          expected_rsps[$];
    logic [SECTOR_W-1:0] head_sector = '0;

    sstf_req_if req_if ();
    sstf_rsp_if rsp_if ();

    assign req_if.valid  = drv_valid;
    assign req_if.op     = drv_op;
    assign req_if.sector = drv_sector;
    assign req_if.tag    = drv_tag;
    assign rsp_if.ready  = rsp_ready;

    sstf_request_scheduler u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Applies one command to the modeled request queue and returns the
    // response the scheduler must produce for it.
    function automatic t_sched_rsp sched_response(t_op op, logic [SECTOR_W-1:0] sector,
                                                  logic [TAG_W-1:0] tag);
        t_sched_rsp          rsp;
        int                  best;
        bit                  found;
        logic [SECTOR_W-1:0] seek_len;
        logic [SECTOR_W-1:0] best_dist;
        rsp       = '0;
        best      = 0;
        found     = 1'b0;
        best_dist = '1;
        case (op)
            OP_ADD: begin
                if (pending_reqs.size() >= QUEUE_DEPTH)
                    rsp.status = ST_FULL;
                else
                    pending_reqs.push_back('{sector, tag});
            end
            OP_DISPATCH: begin
                if (pending_reqs.size() == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    // Strict compare keeps the earliest arrival on a tie.
                    for (int i = 0; i < pending_reqs.size(); i++) begin
                        seek_len = (pending_reqs[i].sector >= head_sector) ?
                                   pending_reqs[i].sector - head_sector :
                                   head_sector - pending_reqs[i].sector;
                        if (i == 0 || seek_len < best_dist) begin
                            best_dist = seek_len;
                            best      = i;
                        end
                    end
                    rsp.dispatched = 1'b1;
                    rsp.sector     = pending_reqs[best].sector;
                    rsp.tag        = pending_reqs[best].tag;
                    head_sector    = pending_reqs[best].sector;
                    pending_reqs.delete(best);
                end
            end
            OP_REMOVE: begin
                for (int i = 0; i < pending_reqs.size(); i++) begin
                    if (!found && pending_reqs[i].tag == tag) begin
                        pending_reqs.delete(i);
                        found = 1'b1;
                    end
                end
                if (!found)
                    rsp.status = ST_NOT_FOUND;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic void queue_cmd(t_op op, logic [SECTOR_W-1:0] sector,
                                      logic [TAG_W-1:0] tag, int unsigned gap,
                                      bit drain_first);
        cmd_queue.push_back('{op, sector, tag, gap, drain_first});
    endfunction

    function automatic logic [SECTOR_W-1:0] rand_wide();
        return SECTOR_W'({$urandom, $urandom});
    endfunction

    function automatic logic [TAG_W-1:0] rand_tag();
        if ($urandom_range(0, 99) < 60)
            return TAG_W'($urandom_range(0, 15));
        return TAG_W'($urandom);
    endfunction

    // Mostly sectors clustered around a base, so that distances are close
    // and ties happen, with extremes and fully random values mixed in.
    function automatic logic [SECTOR_W-1:0] rand_sector(logic [SECTOR_W-1:0] base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return base + SECTOR_W'($urandom_range(0, 64));
        if (r < 50) return base - SECTOR_W'($urandom_range(0, 64));
        if (r < 55) return '0;
        if (r < 60) return SECTOR_MAX;
        return rand_wide();
    endfunction

    function automatic int unsigned rand_gap(int style);
        int r;
        r = $urandom_range(0, 99);
        if (style == 0 || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Request side: predicts each accepted transaction and offers the next
    // queued command once its gap has run out.
    always @(posedge clk) begin
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && req_if.ready)
                expected_rsps.push_back(sched_response(t_op'(drv_op), drv_sector, drv_tag));
            if (!drv_valid || req_if.ready) begin
                if (cmd_queue.size() == 0) begin
                    drv_valid <= 1'b0;
                end else if (cmd_queue[0].gap != 0) begin
                    cmd_queue[0].gap = cmd_queue[0].gap - 1;
                    drv_valid <= 1'b0;
                end else if (cmd_queue[0].drain_first && expected_rsps.size() != 0) begin
                    drv_valid <= 1'b0;
                end else begin
                    drv_valid  <= 1'b1;
                    drv_op     <= cmd_queue[0].op;
                    drv_sector <= cmd_queue[0].sector;
                    drv_tag    <= cmd_queue[0].tag;
                    void'(cmd_queue.pop_front());
                end
            end
        end
    end

    // Response side: checks each transaction and throttles ready.
    always @(posedge clk) begin
        t_sched_rsp want;
        int         r;
        logic       next_ready;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_ready) begin
                rsp_count = rsp_count + 1;
                if (expected_rsps.size() == 0) begin
                    $error("response transaction with no command outstanding");
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp_if.dispatched !== want.dispatched) begin
                        $error("dispatched: expected %0d, got %0d",
                               want.dispatched, rsp_if.dispatched);
                        fail_count = fail_count + 1;
                    end
                    if (rsp_if.out_sector !== want.sector) begin
                        $error("out_sector: expected %h, got %h", want.sector, rsp_if.out_sector);
                        fail_count = fail_count + 1;
                    end
                    if (rsp_if.out_tag !== want.tag) begin
                        $error("out_tag: expected %h, got %h", want.tag, rsp_if.out_tag);
                        fail_count = fail_count + 1;
                    end
                    if (rsp_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                        fail_count = fail_count + 1;
                    end
                end
                // One long hold-off while the sender keeps offering.
                if (rsp_count == LONG_HOLD_AT)
                    hold_left = LONG_HOLD_LEN;
            end

            if (cycle_count % 128 == 0)
                stall_mode = $urandom_range(0, 2);
            cycle_count = cycle_count + 1;

            r = $urandom_range(0, 99);
            if (hold_left > 0) begin
                hold_left  = hold_left - 1;
                next_ready = 1'b0;
            end else if (stall_mode == 0) begin
                next_ready = 1'b1;
            end else if (stall_mode == 1) begin
                next_ready = (r < 80);
                if (r >= 80)
                    hold_left = $urandom_range(0, 2);
            end else begin
                next_ready = (r < 88);
                if (r >= 97)
                    hold_left = $urandom_range(10, 40);
                else if (r >= 88)
                    hold_left = $urandom_range(1, 3);
            end
            rsp_ready <= next_ready;
        end
    end

    initial begin
        int unsigned      made;
        int               kind;
        int               len;
        int               gap_style;
        int               r;
        bit               drain_next;
        bit               forced_drain;
        t_op              op;
        logic [SECTOR_W-1:0] base;
        logic [SECTOR_W-1:0] sector;
        logic [TAG_W-1:0]    tag;
        logic [TAG_W-1:0]    recent_tags[$];

        // Directed opening; the head starts at sector zero.
        queue_cmd(OP_DISPATCH, '0, '0, 0, 0);             // empty queue
        queue_cmd(OP_REMOVE, '0, TAG_MAX, 0, 0);          // unknown tag
        queue_cmd(OP_NONE, SECTOR_MAX, TAG_MAX, 0, 0);    // unused op code
        queue_cmd(OP_ADD, SECTOR_MAX, TAG_MAX, 0, 0);
        queue_cmd(OP_ADD, '0, '0, 0, 0);
        queue_cmd(OP_ADD, 48'd100, 8'd7, 0, 0);
        queue_cmd(OP_ADD, 48'd100, 8'd7, 0, 0);           // duplicate tag
        queue_cmd(OP_DISPATCH, '0, '0, 0, 0);             // sector 0, head stays 0
        queue_cmd(OP_REMOVE, '0, 8'd7, 0, 0);             // earliest of the duplicates
        queue_cmd(OP_DISPATCH, '0, '0, 0, 0);             // head moves to 100
        queue_cmd(OP_ADD, 48'd90, 8'd1, 0, 0);
        queue_cmd(OP_ADD, 48'd110, 8'd2, 0, 0);           // same distance as 90
        queue_cmd(OP_DISPATCH, '0, '0, 0, 0);             // tie goes to the earlier one
        queue_cmd(OP_DISPATCH, '0, '0, 0, 0);
        queue_cmd(OP_DISPATCH, '0, '0, 0, 0);             // head at the top sector
        queue_cmd(OP_ADD, '0, 8'd3, 0, 0);
        queue_cmd(OP_ADD, 48'd1, 8'd4, 0, 0);
        queue_cmd(OP_DISPATCH, '0, '0, 0, 0);             // distance across the full range
        queue_cmd(OP_DISPATCH, '0, '0, 0, 0);
        queue_cmd(OP_DISPATCH, '0, '0, 0, 0);             // empty again
        queue_cmd(OP_REMOVE, '0, 8'd3, 0, 0);             // already dispatched
        queue_cmd(OP_NONE, '0, '0, 0, 0);

        made         = 0;
        forced_drain = 1'b0;
        while (made < RANDOM_CMDS) begin
            kind       = $urandom_range(0, 9);
            gap_style  = $urandom_range(0, 3);
            base       = rand_wide();
            drain_next = ($urandom_range(0, 7) == 0);
            if (!forced_drain && made >= RANDOM_CMDS / 2) begin
                drain_next   = 1'b1;
                forced_drain = 1'b1;
            end
            if (kind <= 4)      len = $urandom_range(10, 40);
            else if (kind <= 6) len = $urandom_range(30, 40);
            else                len = $urandom_range(20, 40);

            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (kind <= 4) begin
                    op = (r < 45) ? OP_ADD : (r < 80) ? OP_DISPATCH :
                         (r < 95) ? OP_REMOVE : OP_NONE;
                end else if (kind <= 6) begin
                    // Bursts of adds to fill the queue and overflow it.
                    op = (r < 92) ? OP_ADD : OP_DISPATCH;
                end else if (kind == 7) begin
                    op = (r < 90) ? OP_DISPATCH : OP_ADD;
                end else begin
                    op = (r < 50) ? OP_ADD : (r < 85) ? OP_REMOVE : OP_DISPATCH;
                end

                sector = (op == OP_ADD) ? rand_sector(base) : rand_wide();
                tag    = rand_tag();
                if (op == OP_REMOVE && recent_tags.size() != 0 && $urandom_range(0, 99) < 70)
                    tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
                if (op == OP_ADD) begin
                    recent_tags.push_back(tag);
                    if (recent_tags.size() > 48)
                        void'(recent_tags.pop_front());
                end

                queue_cmd(op, sector, tag, rand_gap(gap_style), drain_next);
                drain_next = 1'b0;
                made       = made + 1;
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || drv_valid) @(posedge clk);
        while (expected_rsps.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_rsps.size() != 0) begin
            $error("%0d responses never arrived", expected_rsps.size());
            fail_count = fail_count + 1;
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
